// File: hw/rtl/h264fua_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// h264fua_pkg
// Shared types and constants of the H.264 RTP FU-A packetizer.
// ----------------------------------------------------------------------------
package h264fua_pkg;

  localparam int LENGTH_BITS_DEF = 18;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_SOURCE_ID      = 2'd0;
  localparam logic [1:0] REG_PAYLOAD_TYPE   = 2'd1;
  localparam logic [1:0] REG_TIMESTAMP_STEP = 2'd2;
  localparam logic [1:0] REG_MAX_PAYLOAD    = 2'd3;

  // Register reset values
  localparam logic [31:0] SOURCE_ID_RST      = 32'd0;
  localparam logic [6:0]  PAYLOAD_TYPE_RST   = 7'd96;
  localparam logic [31:0] TIMESTAMP_STEP_RST = 32'd3600;
  localparam logic [11:0] MAX_PAYLOAD_RST    = 12'd1448;

  localparam logic [11:0] MIN_PAYLOAD   = 12'd3;
  localparam logic [11:0] FU_OVERHEAD   = 12'd2;
  localparam int          START_CODE_LEN = 4;
  localparam int          FRAME_MIN      = 5;

  // RTP and FU-A byte constants
  localparam logic [7:0] RTP_VERSION_BYTE = 8'h80;
  localparam logic [7:0] NRI_MASK         = 8'hE0;
  localparam logic [7:0] TYPE_MASK        = 8'h1F;
  localparam logic [7:0] FU_A_TYPE        = 8'd28;
  localparam logic [7:0] FU_START_BIT     = 8'h80;
  localparam logic [7:0] FU_END_BIT       = 8'h40;

  // Position within a frame
  localparam logic [2:0] POS_NAL_HEADER = 3'd4;
  localparam logic [2:0] POS_PAYLOAD    = 3'd5;

  // Byte slots of one serialised packet piece
  localparam logic [3:0] IDX_VERSION    = 4'd0;
  localparam logic [3:0] IDX_MARKER_PT  = 4'd1;
  localparam logic [3:0] IDX_SEQ_HI     = 4'd2;
  localparam logic [3:0] IDX_SEQ_LO     = 4'd3;
  localparam logic [3:0] IDX_TS_3       = 4'd4;
  localparam logic [3:0] IDX_TS_2       = 4'd5;
  localparam logic [3:0] IDX_TS_1       = 4'd6;
  localparam logic [3:0] IDX_TS_0       = 4'd7;
  localparam logic [3:0] IDX_SSRC_3     = 4'd8;
  localparam logic [3:0] IDX_SSRC_2     = 4'd9;
  localparam logic [3:0] IDX_SSRC_1     = 4'd10;
  localparam logic [3:0] IDX_SSRC_0     = 4'd11;
  localparam logic [3:0] IDX_FU_IND     = 4'd12;
  localparam logic [3:0] IDX_FU_HDR     = 4'd13;
  localparam logic [3:0] IDX_PLAIN_DATA = 4'd12;
  localparam logic [3:0] IDX_FU_DATA    = 4'd14;
  localparam logic [3:0] IDX_DATA_ONLY  = 4'd0;

  // One classified input byte, as handed from front to back
  typedef struct packed {
    logic        has_header;
    logic        marker;
    logic [15:0] seq;
    logic [31:0] ts;
    logic        fu;
    logic [7:0]  fu_ind;
    logic [7:0]  fu_hdr;
    logic [7:0]  data;
    logic        pend;
  } cmd_t;

  typedef struct packed {
    logic [31:0] timestamp_step;
    logic [11:0] max_payload;
  } front_cfg_t;

  typedef struct packed {
    logic [31:0] source_id;
    logic [6:0]  payload_type;
  } back_cfg_t;

endpackage

// File: hw/rtl/h264fua_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// h264fua channel interfaces
// Frame byte input, packet byte output and register write channels.
// ----------------------------------------------------------------------------
interface h264fua_in_if #(
  parameter int LENGTH_BITS = h264fua_pkg::LENGTH_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic [7:0]             data_byte;
  logic                   frame_start;
  logic [LENGTH_BITS-1:0] frame_length;

  modport source (output valid, data_byte, frame_start, frame_length, input ready);
  modport sink   (input valid, data_byte, frame_start, frame_length, output ready);
endinterface

interface h264fua_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] packet_byte;
  logic       packet_end;
  logic       run_last;

  modport source (output valid, packet_byte, packet_end, run_last, input ready);
  modport sink   (input valid, packet_byte, packet_end, run_last, output ready);
endinterface

interface h264fua_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: hw/rtl/h264fua_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// h264fua_front
// Tracks frame state per input byte and turns the bytes it forwards into commands.
// ----------------------------------------------------------------------------
module h264fua_front #(
  parameter int LENGTH_BITS = h264fua_pkg::LENGTH_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  h264fua_in_if.sink               frame_in,
  input  h264fua_pkg::front_cfg_t  cfg,
  input  logic                     full,
  output logic                     push,
  output h264fua_pkg::cmd_t        push_cmd
);

  localparam int CW = (LENGTH_BITS > 13) ? LENGTH_BITS : 13;

  logic [15:0]            seq, seq_next;
  logic [31:0]            ts, ts_next;
  logic [LENGTH_BITS-1:0] rem, rem_next;
  logic [2:0]             pos, pos_next;
  logic                   fmode, fmode_next;
  logic [7:0]             held, held_next;
  logic [11:0]            fill, fill_next;
  logic                   first_frag, first_frag_next;
  logic                   emit;
  logic                   accept;

  assign frame_in.ready = !full && !rst;
  assign accept = frame_in.valid && frame_in.ready;
  assign push = accept && emit;

  always_comb begin
    logic [LENGTH_BITS-1:0] r;
    logic [11:0]            eff, fmax, fill_inc;
    logic [CW-1:0]          len_w, lim_w;
    logic                   rem_one, frag_end, last_pkt;
    logic [7:0]             fuh;

    eff = (cfg.max_payload < h264fua_pkg::MIN_PAYLOAD) ? h264fua_pkg::MIN_PAYLOAD
                                                      : cfg.max_payload;
    fmax = eff - h264fua_pkg::FU_OVERHEAD;
    len_w = CW'(frame_in.frame_length);
    lim_w = CW'(eff) + CW'(h264fua_pkg::START_CODE_LEN);
    fill_inc = '0;
    rem_one = 1'b0;
    frag_end = 1'b0;
    last_pkt = 1'b0;
    fuh = '0;

    r = rem;
    pos_next = pos;
    fmode_next = fmode;
    fill_next = fill;
    first_frag_next = first_frag;
    ts_next = ts;
    held_next = held;
    emit = 1'b0;
    push_cmd = '0;

    if (frame_in.frame_start) begin
      r = '0;
      pos_next = '0;
      fmode_next = 1'b0;
      fill_next = '0;
      first_frag_next = 1'b1;
      if (len_w >= CW'(h264fua_pkg::FRAME_MIN)) begin
        r = frame_in.frame_length;
        ts_next = ts + cfg.timestamp_step;
        fmode_next = len_w > lim_w;
      end
    end

    rem_next = r;
    if (r != '0) begin
      rem_next = r - LENGTH_BITS'(1);
      rem_one = (r == LENGTH_BITS'(1));
      if (pos_next < h264fua_pkg::POS_NAL_HEADER) begin
        pos_next = pos_next + 3'd1;
      end else if (pos_next == h264fua_pkg::POS_NAL_HEADER) begin
        pos_next = h264fua_pkg::POS_PAYLOAD;
        if (fmode_next) begin
          held_next = frame_in.data_byte;
        end else begin
          emit = 1'b1;
          push_cmd.has_header = 1'b1;
          push_cmd.marker = 1'b1;
          push_cmd.pend = rem_one;
        end
      end else if (!fmode_next) begin
        emit = 1'b1;
        push_cmd.pend = rem_one;
      end else begin
        emit = 1'b1;
        if (fill_next == '0) begin
          frag_end = CW'(r) <= CW'(fmax);
          fuh = held & h264fua_pkg::TYPE_MASK;
          if (first_frag_next) begin
            fuh = fuh | h264fua_pkg::FU_START_BIT;
          end else if (frag_end) begin
            fuh = fuh | h264fua_pkg::FU_END_BIT;
          end
          push_cmd.has_header = 1'b1;
          push_cmd.marker = frag_end;
          push_cmd.fu = 1'b1;
          push_cmd.fu_ind = (held & h264fua_pkg::NRI_MASK) | h264fua_pkg::FU_A_TYPE;
          push_cmd.fu_hdr = fuh;
          first_frag_next = 1'b0;
        end
        fill_inc = fill_next + 12'd1;
        last_pkt = (fill_inc >= fmax) || rem_one;
        push_cmd.pend = last_pkt;
        fill_next = last_pkt ? 12'd0 : fill_inc;
      end
    end

    push_cmd.data = frame_in.data_byte;
    push_cmd.seq = seq;
    push_cmd.ts = ts_next;
    seq_next = push_cmd.has_header ? seq + 16'd1 : seq;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq <= '0;
      ts <= '0;
      rem <= '0;
      pos <= '0;
      fmode <= 1'b0;
      held <= '0;
      fill <= '0;
      first_frag <= 1'b1;
    end else if (accept) begin
      seq <= seq_next;
      ts <= ts_next;
      rem <= rem_next;
      pos <= pos_next;
      fmode <= fmode_next;
      held <= held_next;
      fill <= fill_next;
      first_frag <= first_frag_next;
    end
  end

endmodule

// File: hw/rtl/h264fua_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// h264fua_queue
// Two-entry command queue between the classifier and the serialiser.
// ----------------------------------------------------------------------------
module h264fua_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  h264fua_pkg::cmd_t  push_cmd,
  output logic               full,
  input  logic               pop,
  output h264fua_pkg::cmd_t  head,
  output logic               head_valid
);

  h264fua_pkg::cmd_t entry [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign full = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

// File: hw/rtl/h264fua_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// h264fua_back
// Serialises each queued command: RTP header and FU bytes if present, then data byte.
// ----------------------------------------------------------------------------
module h264fua_back (
  input  logic                    clk,
  input  logic                    rst,
  input  h264fua_pkg::cmd_t       head,
  input  logic                    head_valid,
  output logic                    pop,
  input  h264fua_pkg::back_cfg_t  cfg,
  h264fua_out_if.source           packet_out
);

  logic [3:0] idx;
  logic [3:0] last_idx;
  logic       is_data;
  logic       load;
  logic [7:0] hdr_byte;

  always_comb begin
    if (!head.has_header) begin
      last_idx = h264fua_pkg::IDX_DATA_ONLY;
    end else if (head.fu) begin
      last_idx = h264fua_pkg::IDX_FU_DATA;
    end else begin
      last_idx = h264fua_pkg::IDX_PLAIN_DATA;
    end
  end

  assign is_data = (idx == last_idx);
  assign load = head_valid && (!packet_out.valid || packet_out.ready);
  assign pop = load && is_data;

  always_comb begin
    case (idx)
      h264fua_pkg::IDX_VERSION:   hdr_byte = h264fua_pkg::RTP_VERSION_BYTE;
      h264fua_pkg::IDX_MARKER_PT: hdr_byte = {head.marker, cfg.payload_type};
      h264fua_pkg::IDX_SEQ_HI:    hdr_byte = head.seq[15:8];
      h264fua_pkg::IDX_SEQ_LO:    hdr_byte = head.seq[7:0];
      h264fua_pkg::IDX_TS_3:      hdr_byte = head.ts[31:24];
      h264fua_pkg::IDX_TS_2:      hdr_byte = head.ts[23:16];
      h264fua_pkg::IDX_TS_1:      hdr_byte = head.ts[15:8];
      h264fua_pkg::IDX_TS_0:      hdr_byte = head.ts[7:0];
      h264fua_pkg::IDX_SSRC_3:    hdr_byte = cfg.source_id[31:24];
      h264fua_pkg::IDX_SSRC_2:    hdr_byte = cfg.source_id[23:16];
      h264fua_pkg::IDX_SSRC_1:    hdr_byte = cfg.source_id[15:8];
      h264fua_pkg::IDX_SSRC_0:    hdr_byte = cfg.source_id[7:0];
      h264fua_pkg::IDX_FU_IND:    hdr_byte = head.fu_ind;
      h264fua_pkg::IDX_FU_HDR:    hdr_byte = head.fu_hdr;
      default:                    hdr_byte = head.data;
    endcase
  end

  always_ff @(posedge clk) begin
    if (load) begin
      packet_out.packet_byte <= is_data ? head.data : hdr_byte;
      packet_out.packet_end <= is_data && head.pend;
      packet_out.run_last <= is_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      packet_out.valid <= 1'b0;
      idx <= '0;
    end else begin
      if (load) begin
        packet_out.valid <= 1'b1;
        idx <= is_data ? 4'd0 : idx + 4'd1;
      end else if (packet_out.ready) begin
        packet_out.valid <= 1'b0;
      end
    end
  end

endmodule

// File: hw/rtl/h264_rtp_fua_packetizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// h264_rtp_fua_packetizer
// Turns a start-code framed H.264 byte stream into RTP packets, using single
// NAL unit packets or FU-A fragments, one output byte per transfer.
// ----------------------------------------------------------------------------
//  channel     dir  carries                                   handshake
//  frame_in    in   data_byte, frame_start, frame_length      valid/ready
//  packet_out  out  packet_byte, packet_end, run_last         valid/ready
//  cfg         in   index, data (register write)              valid/ready
//
// A payload byte is registered in the queue and then in the output register;
// a byte that opens a packet is sent as 13 output bytes (single NAL) or 15
// (FU-A), as the serialiser emits one header byte per cycle unless stalled.
// Start code and held NAL header bytes give no output.
// A two-entry queue lets input keep flowing while the output stalls.
// Synchronous reset restores register defaults and clears all frame state.
// ----------------------------------------------------------------------------
module h264_rtp_fua_packetizer #(
  parameter int LENGTH_BITS = h264fua_pkg::LENGTH_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  h264fua_in_if.sink     frame_in,
  h264fua_out_if.source  packet_out,
  h264fua_cfg_if.sink    cfg
);

  logic [31:0] source_id;
  logic [6:0]  payload_type;
  logic [31:0] timestamp_step;
  logic [11:0] max_payload;

  h264fua_pkg::front_cfg_t front_cfg;
  h264fua_pkg::back_cfg_t  back_cfg;
  h264fua_pkg::cmd_t       push_cmd, head;
  logic                    push, full, pop, head_valid;

  assign cfg.ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_id <= h264fua_pkg::SOURCE_ID_RST;
      payload_type <= h264fua_pkg::PAYLOAD_TYPE_RST;
      timestamp_step <= h264fua_pkg::TIMESTAMP_STEP_RST;
      max_payload <= h264fua_pkg::MAX_PAYLOAD_RST;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        h264fua_pkg::REG_SOURCE_ID:      source_id <= cfg.data;
        h264fua_pkg::REG_PAYLOAD_TYPE:   payload_type <= cfg.data[6:0];
        h264fua_pkg::REG_TIMESTAMP_STEP: timestamp_step <= cfg.data;
        h264fua_pkg::REG_MAX_PAYLOAD:    max_payload <= cfg.data[11:0];
        default: ;
      endcase
    end
  end

  assign front_cfg.timestamp_step = timestamp_step;
  assign front_cfg.max_payload = max_payload;
  assign back_cfg.source_id = source_id;
  assign back_cfg.payload_type = payload_type;

  h264fua_front #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .frame_in (frame_in),
    .cfg      (front_cfg),
    .full     (full),
    .push     (push),
    .push_cmd (push_cmd)
  );

  h264fua_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (full),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid)
  );

  h264fua_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .cfg        (back_cfg),
    .packet_out (packet_out)
  );

endmodule
